// ----- hdl/bmcc_pkg.sv -----
package bmcc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned DictN   = 8;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CodeW   = 35;
  localparam int unsigned LenW    = 6;
  localparam int unsigned RunW    = 3;
  localparam int unsigned OutDataW = 48;

  localparam logic [RunW-1:0] RunCap = 3'd4;

  // format prefixes
  localparam logic [2:0] PfxRun    = 3'b000;
  localparam logic [2:0] PfxMask   = 3'b001;
  localparam logic [2:0] PfxOne    = 3'b010;
  localparam logic [2:0] PfxAdj    = 3'b011;
  localparam logic [2:0] PfxTwo    = 3'b100;
  localparam logic [2:0] PfxDirect = 3'b101;
  localparam logic [2:0] PfxRaw    = 3'b110;

  localparam logic [LenW-1:0] LenRun    = 6'd5;
  localparam logic [LenW-1:0] LenDirect = 6'd6;
  localparam logic [LenW-1:0] LenOne    = 6'd11;
  localparam logic [LenW-1:0] LenMask   = 6'd15;
  localparam logic [LenW-1:0] LenTwo    = 6'd16;
  localparam logic [LenW-1:0] LenRaw    = 6'd35;

  localparam logic [PosW-1:0] MaskStartMax = 5'd28;

  typedef logic [DictN-1:0][WordW-1:0] dict_t;

  typedef struct packed {
    logic       flush_en;
    logic [1:0] flush_cc;
    logic       enc_en;
  } run_dec_t;

  typedef struct packed {
    logic [CodeW-1:0] bits;
    logic [LenW-1:0]  len;
  } code_t;

endpackage

// ----- hdl/bmcc_cfg.sv -----
module bmcc_cfg import bmcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output dict_t       dict_o
);

  dict_t dict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_q <= '0;
    end else if (psel && penable && pwrite) begin
      dict_q[paddr[4:2]] <= pwdata;
    end
  end

  assign prdata = dict_q[paddr[4:2]];
  assign pready = 1'b1;
  assign dict_o = dict_q;

endmodule

// ----- hdl/bmcc_run_ctrl.sv -----
module bmcc_run_ctrl import bmcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [WordW-1:0] word_i,
  input  logic             eos_i,
  output run_dec_t         dec_o
);

  logic [WordW-1:0] prev_q, prev_d;
  logic             have_q, have_d;
  logic [RunW-1:0]  rc_q, rc_d;
  logic [RunW-1:0]  cnt;
  logic             repeat_hit;

  assign repeat_hit = have_q && (word_i == prev_q);
  assign cnt        = rc_q + 3'd1;

  always_comb begin
    dec_o  = '0;
    prev_d = prev_q;
    have_d = have_q;
    rc_d   = rc_q;
    if (repeat_hit) begin
      // repeat: counted, flushed at the cap or at end of stream
      dec_o.flush_en = (cnt == RunCap) || eos_i;
      dec_o.flush_cc = 2'(cnt - 3'd1);
      rc_d           = dec_o.flush_en ? '0 : cnt;
    end else begin
      dec_o.flush_en = (rc_q != '0);
      dec_o.flush_cc = 2'(rc_q - 3'd1);
      dec_o.enc_en   = 1'b1;
      rc_d           = '0;
      prev_d         = word_i;
      have_d         = 1'b1;
    end
    if (eos_i) begin
      prev_d = '0;
      have_d = 1'b0;
      rc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      have_q <= 1'b0;
      rc_q   <= '0;
    end else if (accept_i) begin
      prev_q <= prev_d;
      have_q <= have_d;
      rc_q   <= rc_d;
    end
  end

  a_rc_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q < RunCap) else $error("run count reached cap without flush");

  a_no_prev_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q |-> (rc_q == '0)) else $error("pending run without previous word");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eos_i) |=> (!have_q && rc_q == '0))
    else $error("end of stream did not clear run state");

endmodule

// ----- hdl/bmcc_encoder.sv -----
module bmcc_encoder import bmcc_pkg::*; (
  input  logic [WordW-1:0] word_i,
  input  dict_t            dict_i,
  output code_t            code_o
);

  function automatic logic [PosW-1:0] first_pos(input logic [WordW-1:0] d);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (d[WordW-1-i]) p = PosW'(i);
    end
    return p;
  endfunction

  function automatic logic [PosW-1:0] last_pos(input logic [WordW-1:0] d);
    logic [PosW-1:0] p;
    p = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (d[b]) p = PosW'(WordW - 1 - b);
    end
    return p;
  endfunction

  function automatic logic [IdxW-1:0] lowest(input logic [DictN-1:0] v);
    logic [IdxW-1:0] k;
    k = '0;
    for (int j = DictN - 1; j >= 0; j--) begin
      if (v[j]) k = IdxW'(j);
    end
    return k;
  endfunction

  logic [DictN-1:0][WordW-1:0] diff;
  logic [DictN-1:0][LenW-1:0]  pc;
  logic [DictN-1:0][PosW-1:0]  fp, lp, span;
  logic [DictN-1:0]            hit_dir, hit_one, hit_adj, hit_msk, hit_two;

  logic [IdxW-1:0]  idx_dir, idx_one, idx_adj, idx_msk, idx_two;
  logic [PosW-1:0]  msk_start;
  logic [WordW-1:0] msk_word;
  logic [3:0]       msk_bits;

  always_comb begin
    for (int j = 0; j < DictN; j++) begin
      diff[j]    = word_i ^ dict_i[j];
      pc[j]      = LenW'($countones(diff[j]));
      fp[j]      = first_pos(diff[j]);
      lp[j]      = last_pos(diff[j]);
      span[j]    = lp[j] - fp[j];
      hit_dir[j] = (pc[j] == 6'd0);
      hit_one[j] = (pc[j] == 6'd1);
      hit_adj[j] = (pc[j] == 6'd2) && (span[j] == 5'd1);
      hit_msk[j] = (pc[j] <= 6'd4) && (span[j] <= 5'd3);
      hit_two[j] = (pc[j] == 6'd2);
    end
  end

  assign idx_dir = lowest(hit_dir);
  assign idx_one = lowest(hit_one);
  assign idx_adj = lowest(hit_adj);
  assign idx_msk = lowest(hit_msk);
  assign idx_two = lowest(hit_two);

  // window start is clamped so that all four mask bits lie inside the word
  assign msk_start = (fp[idx_msk] > MaskStartMax) ? MaskStartMax : fp[idx_msk];
  assign msk_word  = diff[idx_msk] >> (MaskStartMax - msk_start);
  assign msk_bits  = msk_word[3:0];

  always_comb begin
    if (|hit_dir) begin
      code_o.bits = CodeW'({PfxDirect, idx_dir});
      code_o.len  = LenDirect;
    end else if (|hit_one) begin
      code_o.bits = CodeW'({PfxOne, fp[idx_one], idx_one});
      code_o.len  = LenOne;
    end else if (|hit_adj) begin
      code_o.bits = CodeW'({PfxAdj, fp[idx_adj], idx_adj});
      code_o.len  = LenOne;
    end else if (|hit_msk) begin
      code_o.bits = CodeW'({PfxMask, msk_start, msk_bits, idx_msk});
      code_o.len  = LenMask;
    end else if (|hit_two) begin
      code_o.bits = CodeW'({PfxTwo, fp[idx_two], lp[idx_two], idx_two});
      code_o.len  = LenTwo;
    end else begin
      code_o.bits = {PfxRaw, word_i};
      code_o.len  = LenRaw;
    end
  end

endmodule

// ----- hdl/bitmask_code_compressor.sv -----
// A codeword passes through the stage-1 register and then the output register.
// Throughput: one instruction per cycle without back-pressure; an instruction that both
//   closes a run and is coded holds the input, as the output takes one codeword a cycle.
// A repeat that produces no codeword is absorbed at the input and never enters stage 1.
// Reset (rst_ni low, asynchronous): run state, pipeline and output valid cleared,
//   dictionary words reset to zero.
module bitmask_code_compressor import bmcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // [31:0] instr_word
  input  logic                s_axis_tlast,  // end_of_stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [34:0] code_bits, [40:35] code_length
  output logic                m_axis_tlast,  // last_result
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dict_t    dict;
  run_dec_t dec;
  code_t    enc_code, sel_code;
  logic     accept;

  logic             s1_valid_q;
  run_dec_t         s1_dec_q;
  logic [WordW-1:0] s1_word_q;

  logic             out_valid_q;
  code_t            out_code_q;
  logic             out_last_q;

  logic             out_load, s1_final, s1_load;

  bmcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dict_o  (dict)
  );

  assign accept = s_axis_tvalid && s_axis_tready;

  bmcc_run_ctrl u_run_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (s_axis_tdata),
    .eos_i    (s_axis_tlast),
    .dec_o    (dec)
  );

  bmcc_encoder u_encoder (
    .word_i (s1_word_q),
    .dict_i (dict),
    .code_o (enc_code)
  );

  assign out_load = s1_valid_q && (!out_valid_q || m_axis_tready);
  // the run codeword goes out first; the item is done once its last codeword moves on
  assign s1_final = !(s1_dec_q.flush_en && s1_dec_q.enc_en);
  assign s_axis_tready = !s1_valid_q || (out_load && s1_final);
  assign s1_load  = accept && (dec.flush_en || dec.enc_en);

  always_comb begin
    if (s1_dec_q.flush_en) begin
      sel_code.bits = CodeW'({PfxRun, s1_dec_q.flush_cc});
      sel_code.len  = LenRun;
    end else begin
      sel_code = enc_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      s1_dec_q  <= dec;
      s1_word_q <= s_axis_tdata;
    end else if (out_load) begin
      s1_dec_q.flush_en <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= sel_code;
      out_last_q <= s1_final;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CodeW - LenW){1'b0}}, out_code_q.len, out_code_q.bits};
  assign m_axis_tlast  = out_last_q;

  a_s1_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_dec_q.flush_en || s1_dec_q.enc_en))
    else $error("stage holds a transaction with no codeword");

  a_stall_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready) ||
                       (s1_valid_q && !s1_final))
    else $error("input stalled without cause");

  a_flush_then_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !s1_final) |=> (s1_valid_q && !s1_dec_q.flush_en && s1_dec_q.enc_en))
    else $error("codeword lost after run flush");

endmodule
